// ----- src/kms_pkg.sv -----
// Shared types, codes and defaults for the keypad matrix scanner.
package kms_pkg;

    // Default matrix geometry.
    localparam int ROW_COUNT_DEF    = 5;
    localparam int COLUMN_COUNT_DEF = 5;

    // Field widths fixed by the interface.
    localparam int SAMPLE_W = 5;
    localparam int ROW_W    = 3;
    localparam int CODE_W   = 5;
    localparam int ACTION_W = 2;
    localparam int DIGIT_W  = 4;
    localparam int COUNT_W  = 8;

    // Register reset values.
    localparam logic [COUNT_W-1:0] PRESS_HOLD_RESET    = 8'd100;
    localparam logic [COUNT_W-1:0] RELEASE_QUIET_RESET = 8'd100;

    // Configuration register indexes.
    typedef enum logic [0:0] {
        CFG_PRESS_HOLD    = 1'b0,
        CFG_RELEASE_QUIET = 1'b1
    } cfg_index_t;

    // Key action codes.
    typedef enum logic [ACTION_W-1:0] {
        ACT_NONE  = 2'd0,
        ACT_DIGIT = 2'd1,
        ACT_CLEAR = 2'd2
    } key_action_t;

    // What the scan core reports for one sample.
    typedef struct packed {
        logic [ROW_W-1:0]  row_drive;
        logic              key_event;
        logic [CODE_W-1:0] press_code;
    } scan_out_t;

    // Decoded meaning of a key code.
    typedef struct packed {
        key_action_t        key_action;
        logic [DIGIT_W-1:0] digit_value;
    } key_map_t;

endpackage

// ----- src/kms_scan_core.sv -----
// Scan state machine: row walk, press hold and release quiet counting.
module kms_scan_core #(
    parameter int ROW_COUNT    = kms_pkg::ROW_COUNT_DEF,
    parameter int COLUMN_COUNT = kms_pkg::COLUMN_COUNT_DEF
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         step,
    input  logic [kms_pkg::SAMPLE_W-1:0] sample_raw,
    input  logic [kms_pkg::COUNT_W-1:0]  hold_need,
    input  logic [kms_pkg::COUNT_W-1:0]  quiet_need,
    output kms_pkg::scan_out_t           scan_out
);

    localparam logic [kms_pkg::SAMPLE_W-1:0] COL_MASK =
        kms_pkg::SAMPLE_W'((64'd1 << COLUMN_COUNT) - 64'd1);
    localparam logic [kms_pkg::ROW_W-1:0] LAST_ROW = kms_pkg::ROW_W'(ROW_COUNT - 1);
    localparam logic [kms_pkg::CODE_W:0]  COL_MULT = (kms_pkg::CODE_W + 1)'(COLUMN_COUNT);

    typedef enum logic [2:0] {
        PH_SCAN  = 3'b001,
        PH_HOLD  = 3'b010,
        PH_QUIET = 3'b100
    } phase_t;

    phase_t                        phase_reg, phase_next;
    logic [kms_pkg::ROW_W-1:0]     row_reg, row_next;
    logic [kms_pkg::COUNT_W-1:0]   count_reg, count_next;

    logic [kms_pkg::SAMPLE_W-1:0]  sample;
    logic                          sample_zero;
    logic                          sample_single;
    logic [kms_pkg::ROW_W-1:0]     row_adv;
    logic [kms_pkg::COUNT_W-1:0]   count_inc;
    logic [2:0]                    col_idx;
    logic [kms_pkg::CODE_W:0]      code_full;
    logic                          event_now;

    // Sample conditioning and helpers.
    assign sample        = sample_raw & COL_MASK;
    assign sample_zero   = (sample == '0);
    assign sample_single = ((sample & (sample - 1'b1)) == '0);
    assign row_adv       = (row_reg >= LAST_ROW) ? '0 : row_reg + 1'b1;
    assign count_inc     = count_reg + 1'b1;

    // Column position of the lowest set bit.
    always_comb begin
        col_idx = '0;
        for (int i = kms_pkg::SAMPLE_W - 1; i >= 0; i--) begin
            if (sample[i]) begin
                col_idx = 3'(i);
            end
        end
    end

    assign code_full = COL_MULT * {3'b000, row_reg} + {3'b000, col_idx};

    // Next state for one sample.
    always_comb begin
        phase_next = phase_reg;
        row_next   = row_reg;
        count_next = count_reg;
        event_now  = 1'b0;
        unique case (phase_reg)
            PH_HOLD: begin
                if (sample_zero) begin
                    phase_next = PH_SCAN;
                    count_next = '0;
                    row_next   = row_adv;
                end else if (count_inc >= hold_need) begin
                    count_next = '0;
                    if (sample_single) begin
                        event_now  = 1'b1;
                        phase_next = PH_QUIET;
                    end else begin
                        phase_next = PH_SCAN;
                        row_next   = row_adv;
                    end
                end else begin
                    count_next = count_inc;
                end
            end
            PH_QUIET: begin
                if (!sample_zero) begin
                    count_next = '0;
                end else if (count_inc >= quiet_need) begin
                    count_next = '0;
                    phase_next = PH_SCAN;
                    row_next   = row_adv;
                end else begin
                    count_next = count_inc;
                end
            end
            default: begin
                count_next = '0;
                if (sample_zero) begin
                    phase_next = PH_SCAN;
                    row_next   = row_adv;
                end else begin
                    phase_next = PH_HOLD;
                end
            end
        endcase
    end

    // State registers advance once per processed word.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= PH_SCAN;
            row_reg   <= '0;
            count_reg <= '0;
        end else if (step) begin
            phase_reg <= phase_next;
            row_reg   <= row_next;
            count_reg <= count_next;
        end
    end

    // Report for the current word.
    assign scan_out.row_drive  = row_reg;
    assign scan_out.key_event  = event_now;
    assign scan_out.press_code = event_now ? code_full[kms_pkg::CODE_W-1:0] : '0;

endmodule

// ----- src/kms_key_map.sv -----
// Key code to digit or clear action decoder.
module kms_key_map (
    input  logic [kms_pkg::CODE_W-1:0] press_code,
    output kms_pkg::key_map_t          key_map
);

    // Digit keys sit in a 3x3 block plus zero above it; the last key clears.
    always_comb begin
        key_map.key_action  = kms_pkg::ACT_DIGIT;
        key_map.digit_value = '0;
        unique case (press_code)
            5'd2:    key_map.digit_value = 4'd0;
            5'd6:    key_map.digit_value = 4'd1;
            5'd7:    key_map.digit_value = 4'd2;
            5'd8:    key_map.digit_value = 4'd3;
            5'd11:   key_map.digit_value = 4'd4;
            5'd12:   key_map.digit_value = 4'd5;
            5'd13:   key_map.digit_value = 4'd6;
            5'd16:   key_map.digit_value = 4'd7;
            5'd17:   key_map.digit_value = 4'd8;
            5'd18:   key_map.digit_value = 4'd9;
            5'd24:   key_map.key_action  = kms_pkg::ACT_CLEAR;
            default: key_map.key_action  = kms_pkg::ACT_NONE;
        endcase
    end

endmodule

// ----- src/keypad_matrix_scanner_top.sv -----
// Path: the result word for a sample is presented after the sample word passes
// through the input register, then the result register.
// Throughput: one word per cycle while m_ready does not stall; the scan state
// updates once per word, in a single pass between the input and result registers.
// Reset (synchronous, active low): scan phase, row 0, count 0, both
// thresholds at 100, input and result registers empty.
module keypad_matrix_scanner_top #(
    parameter int ROW_COUNT    = kms_pkg::ROW_COUNT_DEF,
    parameter int COLUMN_COUNT = kms_pkg::COLUMN_COUNT_DEF
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         s_valid,
    output logic                         s_ready,
    input  logic [kms_pkg::SAMPLE_W-1:0] s_column_sample,
    output logic                         m_valid,
    input  logic                         m_ready,
    output logic [kms_pkg::ROW_W-1:0]    m_row_drive,
    output logic                         m_key_event,
    output logic [kms_pkg::CODE_W-1:0]   m_press_code,
    output logic [kms_pkg::ACTION_W-1:0] m_key_action,
    output logic [kms_pkg::DIGIT_W-1:0]  m_digit_value,
    input  logic                         cfg_valid,
    output logic                         cfg_ready,
    input  logic [0:0]                   cfg_index,
    input  logic [kms_pkg::COUNT_W-1:0]  cfg_data
);

    logic                          in_valid_reg;
    logic [kms_pkg::SAMPLE_W-1:0]  in_sample_reg;
    logic                          out_valid_reg;
    kms_pkg::scan_out_t            out_scan_reg;
    kms_pkg::key_map_t             out_map_reg;
    logic [kms_pkg::COUNT_W-1:0]   hold_ticks_reg;
    logic [kms_pkg::COUNT_W-1:0]   quiet_ticks_reg;

    logic                          out_free;
    logic                          step;
    logic [kms_pkg::COUNT_W-1:0]   hold_need;
    logic [kms_pkg::COUNT_W-1:0]   quiet_need;
    kms_pkg::scan_out_t            scan_out;
    kms_pkg::key_map_t             key_map;

    // Pipeline flow: a word moves on when the result register is free.
    assign out_free = !out_valid_reg || m_ready;
    assign step     = in_valid_reg && out_free;
    assign s_ready  = !in_valid_reg || out_free;

    // Configuration registers; a zero threshold behaves as one.
    assign cfg_ready  = 1'b1;
    assign hold_need  = (hold_ticks_reg == '0) ? 8'd1 : hold_ticks_reg;
    assign quiet_need = (quiet_ticks_reg == '0) ? 8'd1 : quiet_ticks_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            hold_ticks_reg  <= kms_pkg::PRESS_HOLD_RESET;
            quiet_ticks_reg <= kms_pkg::RELEASE_QUIET_RESET;
        end else if (cfg_valid) begin
            unique case (cfg_index)
                kms_pkg::CFG_PRESS_HOLD:    hold_ticks_reg  <= cfg_data;
                kms_pkg::CFG_RELEASE_QUIET: quiet_ticks_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    // Input register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_ready) begin
            in_valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_sample_reg <= s_column_sample;
        end
    end

    kms_scan_core #(
        .ROW_COUNT    (ROW_COUNT),
        .COLUMN_COUNT (COLUMN_COUNT)
    ) u_core (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .step       (step),
        .sample_raw (in_sample_reg),
        .hold_need  (hold_need),
        .quiet_need (quiet_need),
        .scan_out   (scan_out)
    );

    kms_key_map u_map (
        .press_code (scan_out.press_code),
        .key_map    (key_map)
    );

    // Result register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (out_free) begin
            out_valid_reg <= in_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (step) begin
            out_scan_reg <= scan_out;
            out_map_reg  <= key_map;
        end
    end

    assign m_valid       = out_valid_reg;
    assign m_row_drive   = out_scan_reg.row_drive;
    assign m_key_event   = out_scan_reg.key_event;
    assign m_press_code  = out_scan_reg.press_code;
    assign m_key_action  = out_map_reg.key_action;
    assign m_digit_value = out_map_reg.digit_value;

endmodule
